[rtl/pdvc_pkg.sv]
// ----------------------------------------------------------------------------
// pdvc_pkg
// Widths, codes and band tables shared by the PLL divider / VCO cap search
// block and its port checker.
// ----------------------------------------------------------------------------
package pdvc_pkg;

    // field widths
    localparam int TARGET_W   = 32;
    localparam int BANK_W     = 7;
    localparam int COMP_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int BAND_W     = 6;
    localparam int INT_W      = 9;
    localparam int FRAC_OUT_W = 23;
    localparam int CAP_OUT_W  = 6;
    localparam int ACT_W      = 32;
    localparam int REF_W      = 30;

    // stream words
    localparam int S_TDATA_W  = 48;
    localparam int S_PAD_W    = S_TDATA_W - TARGET_W - BANK_W - COMP_W;
    localparam int M_TDATA_W  = 88;
    localparam int M_PAD_W    = M_TDATA_W - BANK_W - BAND_W - INT_W - FRAC_OUT_W
                                - CAP_OUT_W - ACT_W;

    // x*f can reach 16 * 2^32
    localparam int XF_W       = TARGET_W + 4;

    localparam logic [REF_W-1:0] REF_RESET = REF_W'(26000000);

    localparam int CAP_STEPS_DEF = 64;
    localparam int FRAC_BITS_DEF = 23;

    localparam int NUM_BANDS = 16;

    localparam logic [TARGET_W-1:0] BAND_EDGE [NUM_BANDS+1] = '{
        32'd232500000,  32'd285625000,  32'd336875000,  32'd405000000,
        32'd465000000,  32'd571250000,  32'd673750000,  32'd810000000,
        32'd930000000,  32'd1142500000, 32'd1347500000, 32'd1620000000,
        32'd1860000000, 32'd2285000000, 32'd2695000000, 32'd3240000000,
        32'd3720000000
    };

    localparam logic [BAND_W-1:0] BAND_CODE [NUM_BANDS] = '{
        6'h27, 6'h2f, 6'h37, 6'h3f, 6'h26, 6'h2e, 6'h36, 6'h3e,
        6'h25, 6'h2d, 6'h35, 6'h3d, 6'h24, 6'h2c, 6'h34, 6'h3c
    };

    // opcodes (s_tuser)
    localparam logic OP_START = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // comparator readings
    localparam logic [COMP_W-1:0] COMP_NORMAL  = 2'd0;
    localparam logic [COMP_W-1:0] COMP_LOW     = 2'd1;
    localparam logic [COMP_W-1:0] COMP_HIGH    = 2'd2;
    localparam logic [COMP_W-1:0] COMP_INVALID = 2'd3;

    // result status (m_tuser)
    localparam logic [STATUS_W-1:0] STAT_SWEEPING  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OUT_BAND  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_READ  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NO_WINDOW = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_IGNORED   = 3'd5;

    // window tracking
    localparam logic [1:0] PH_ABOVE = 2'd0;
    localparam logic [1:0] PH_IN    = 2'd1;
    localparam logic [1:0] PH_BELOW = 2'd2;

endpackage

[rtl/pll_divider_and_vco_cap_search.sv]
// ----------------------------------------------------------------------------
// pll_divider_and_vco_cap_search
// Band lookup, fractional-N divider and actual frequency computation, then a
// VCO capacitor sweep that tracks the normal window and settles on its middle.
// ----------------------------------------------------------------------------
// Sequencing: a reading word or an out-of-band start gives its result in the
//   cycle after acceptance. An in-band start runs through S_DIV, S_MUL and
//   S_FIN: one restoring divider bit per cycle, then one shift-add multiply
//   step per reference bit, both on a single shared adder.
// Throughput: one word at a time; s_tready is low while busy or while a result
//   waits on the master side.
// Reset: synchronous, active low; no sweep active, reference back to 26 MHz.
module pll_divider_and_vco_cap_search
    import pdvc_pkg::*;
#(
    parameter int CAP_STEPS = CAP_STEPS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration: ref_clock_hz
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REF_W-1:0]     cfg_data,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // target_freq_hz, bank_base, comparator
    input  logic                 s_tuser,   // opcode
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // bank_out, band_select, int_divider,
                                            // frac_divider, cap_code, actual_freq_hz
    output logic [STATUS_W-1:0]  m_tuser    // status
);

    localparam int CAP_W     = (CAP_STEPS > 1) ? $clog2(CAP_STEPS) : 1;
    localparam int Q_W       = INT_W + FRAC_BITS;
    localparam int P_W       = Q_W + REF_W;
    localparam int ALU_W     = (REF_W + 1 > Q_W) ? REF_W + 1 : Q_W;
    localparam int DIV_STEPS = XF_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(((DIV_STEPS > REF_W) ? DIV_STEPS : REF_W) + 1);
    localparam int SH_W      = $clog2(FRAC_BITS + 5);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_FIN} state_t;

    // input fields
    logic [TARGET_W-1:0] in_target;
    logic [BANK_W-1:0]   in_bank;
    logic [COMP_W-1:0]   in_comp;
    assign in_target = s_tdata[TARGET_W-1:0];
    assign in_bank   = s_tdata[TARGET_W +: BANK_W];
    assign in_comp   = s_tdata[TARGET_W+BANK_W +: COMP_W];

    // registers
    state_t              state_reg, state_next;
    logic [REF_W-1:0]    ref_reg, ref_next;
    logic                sweep_reg, sweep_next;
    logic [CAP_W-1:0]    cap_idx_reg, cap_idx_next;
    logic [1:0]          phase_reg, phase_next;
    logic [CAP_W-1:0]    win_start_reg, win_start_next;
    logic [CAP_W-1:0]    win_stop_reg, win_stop_next;
    logic [BAND_W-1:0]   held_band_reg, held_band_next;
    logic [INT_W-1:0]    held_int_reg, held_int_next;
    logic [FRAC_OUT_W-1:0] held_frac_reg, held_frac_next;
    logic [ACT_W-1:0]    held_act_reg, held_act_next;
    logic [BANK_W-1:0]   held_bank_reg, held_bank_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [XF_W-1:0]     xf_reg, xf_next;
    logic [REF_W-1:0]    rem_reg, rem_next;
    logic [Q_W-1:0]      q_reg, q_next;
    logic                ovf_reg, ovf_next;
    logic [Q_W-1:0]      hi_reg, hi_next;
    logic [REF_W-1:0]    lo_reg, lo_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // shared adder
    logic [ALU_W-1:0]    alu_a, alu_b;
    logic                alu_sub;
    logic [ALU_W:0]      alu_sum;
    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + {{ALU_W{1'b0}}, alu_sub};

    // band lookup
    logic                in_band;
    logic [3:0]          band_idx;
    logic [BAND_W-1:0]   band_code;
    logic [2:0]          band_k, held_k;

    always_comb begin
        band_idx = '0;
        for (int i = 0; i < NUM_BANDS; i++) begin
            if (in_target > BAND_EDGE[i]) band_idx = 4'(i);
        end
    end

    assign in_band   = (in_target > BAND_EDGE[0]) && (in_target <= BAND_EDGE[NUM_BANDS]);
    assign band_code = BAND_CODE[band_idx];
    assign band_k    = band_code[2:0] - 3'd3;
    assign held_k    = held_band_reg[2:0] - 3'd3;

    logic [REF_W-1:0]    ref_eff;
    assign ref_eff = (ref_reg == '0) ? REF_W'(1) : ref_reg;

    // datapath helpers
    logic [REF_W:0]      div_r2;
    logic                div_ok;
    logic [Q_W-1:0]      q_step;
    logic                ovf_step;
    logic [Q_W:0]        mul_t;
    logic [P_W-1:0]      prod, prod_sh;
    logic [SH_W-1:0]     sh_amt;
    logic [ACT_W-1:0]    act_val;
    logic [CAP_W:0]      mid_sum;
    logic [CAP_W-1:0]    cap_out;
    logic [CAP_W-1:0]    last_cap;

    assign div_r2   = {rem_reg, xf_reg[XF_W-1]};
    assign div_ok   = alu_sum[ALU_W];
    assign q_step   = {q_reg[Q_W-2:0], div_ok};
    assign ovf_step = ovf_reg | q_reg[Q_W-1];
    assign mul_t    = lo_reg[0] ? alu_sum[Q_W:0] : {1'b0, hi_reg};
    assign prod     = {hi_reg, lo_reg};
    assign sh_amt   = SH_W'(FRAC_BITS) + SH_W'(held_k);
    assign prod_sh  = prod >> sh_amt;
    assign act_val  = (|prod_sh[P_W-1:ACT_W]) ? '1 : prod_sh[ACT_W-1:0];
    assign last_cap = CAP_W'(CAP_STEPS - 1);

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_DIV: begin
                alu_a   = ALU_W'(div_r2);
                alu_b   = ALU_W'(ref_eff);
                alu_sub = 1'b1;
            end
            S_MUL: begin
                alu_a = ALU_W'(hi_reg);
                alu_b = ALU_W'(q_reg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        ref_next       = ref_reg;
        sweep_next     = sweep_reg;
        cap_idx_next   = cap_idx_reg;
        phase_next     = phase_reg;
        win_start_next = win_start_reg;
        win_stop_next  = win_stop_reg;
        held_band_next = held_band_reg;
        held_int_next  = held_int_reg;
        held_frac_next = held_frac_reg;
        held_act_next  = held_act_reg;
        held_bank_next = held_bank_reg;
        cnt_next       = cnt_reg;
        xf_next        = xf_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        ovf_next       = ovf_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_status_next  = m_status_reg;
        m_data_next    = m_data_reg;
        mid_sum        = '0;
        cap_out        = '0;

        if (cfg_valid) ref_next = cfg_data;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (s_tuser == OP_START) begin
                        sweep_next = 1'b0;
                        if (!in_band) begin
                            m_valid_next  = 1'b1;
                            m_status_next = STAT_OUT_BAND;
                            m_data_next   = M_TDATA_W'(in_bank);
                        end else begin
                            held_band_next = band_code;
                            held_bank_next = in_bank;
                            xf_next        = XF_W'(in_target) << band_k;
                            rem_next       = '0;
                            q_next         = '0;
                            ovf_next       = 1'b0;
                            cnt_next       = '0;
                            state_next     = S_DIV;
                        end
                    end else if (!sweep_reg) begin
                        m_valid_next  = 1'b1;
                        m_status_next = STAT_IGNORED;
                        m_data_next   = '0;
                    end else if (in_comp == COMP_INVALID) begin
                        sweep_next    = 1'b0;
                        m_valid_next  = 1'b1;
                        m_status_next = STAT_BAD_READ;
                        m_data_next   = {M_PAD_W'(0), held_act_reg, CAP_OUT_W'(cap_idx_reg),
                                         held_frac_reg, held_int_reg, held_band_reg,
                                         held_bank_reg};
                    end else begin
                        if (in_comp == COMP_LOW && phase_reg == PH_IN) begin
                            win_stop_next = cap_idx_reg - CAP_W'(1);
                            phase_next    = PH_BELOW;
                        end else if (in_comp == COMP_NORMAL && phase_reg == PH_ABOVE) begin
                            win_start_next = cap_idx_reg;
                            phase_next     = PH_IN;
                        end
                        m_valid_next = 1'b1;
                        if (cap_idx_reg >= last_cap) begin
                            sweep_next = 1'b0;
                            if (phase_next == PH_IN) win_stop_next = last_cap;
                            mid_sum = {1'b0, win_start_next} + {1'b0, win_stop_next};
                            if (phase_next == PH_ABOVE) begin
                                m_status_next = STAT_NO_WINDOW;
                                cap_out       = '0;
                            end else begin
                                m_status_next = STAT_DONE;
                                cap_out       = mid_sum[CAP_W:1];
                            end
                        end else begin
                            cap_idx_next  = cap_idx_reg + CAP_W'(1);
                            m_status_next = STAT_SWEEPING;
                            cap_out       = cap_idx_next;
                        end
                        m_data_next = {M_PAD_W'(0), held_act_reg, CAP_OUT_W'(cap_out),
                                       held_frac_reg, held_int_reg, held_band_reg,
                                       held_bank_reg};
                    end
                end
            end
            S_DIV: begin
                // restoring divide: (x*f << FRAC_BITS) / ref, one quotient bit a cycle
                xf_next  = {xf_reg[XF_W-2:0], 1'b0};
                rem_next = div_ok ? alu_sum[REF_W-1:0] : div_r2[REF_W-1:0];
                q_next   = q_step;
                ovf_next = ovf_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    // saturate integer part above its range
                    if (ovf_step) q_next = '1;
                    hi_next    = '0;
                    lo_next    = ref_eff;
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                // shift-add: q * ref, one reference bit a cycle
                hi_next  = mul_t[Q_W:1];
                lo_next  = {mul_t[0], lo_reg[REF_W-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(REF_W - 1)) state_next = S_FIN;
            end
            S_FIN: begin
                held_int_next  = q_reg[Q_W-1:FRAC_BITS];
                held_frac_next = FRAC_OUT_W'(q_reg[FRAC_BITS-1:0]);
                held_act_next  = act_val;
                sweep_next     = 1'b1;
                cap_idx_next   = '0;
                phase_next     = PH_ABOVE;
                win_start_next = '0;
                win_stop_next  = '0;
                m_valid_next   = 1'b1;
                m_status_next  = STAT_SWEEPING;
                m_data_next    = {M_PAD_W'(0), act_val, CAP_OUT_W'(0),
                                  FRAC_OUT_W'(q_reg[FRAC_BITS-1:0]),
                                  q_reg[Q_W-1:FRAC_BITS], held_band_reg, held_bank_reg};
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ref_reg     <= REF_RESET;
            sweep_reg   <= 1'b0;
            cap_idx_reg <= '0;
            phase_reg   <= PH_ABOVE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ref_reg     <= ref_next;
            sweep_reg   <= sweep_next;
            cap_idx_reg <= cap_idx_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        win_start_reg <= win_start_next;
        win_stop_reg  <= win_stop_next;
        held_band_reg <= held_band_next;
        held_int_reg  <= held_int_next;
        held_frac_reg <= held_frac_next;
        held_act_reg  <= held_act_next;
        held_bank_reg <= held_bank_next;
        xf_reg        <= xf_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        ovf_reg       <= ovf_next;
        hi_reg        <= hi_next;
        lo_reg        <= lo_next;
        m_status_reg  <= m_status_next;
        m_data_reg    <= m_data_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_status_reg;

endmodule

[rtl/pdvc_checker.sv]
// ----------------------------------------------------------------------------
// pdvc_checker
// Port-level checks for the PLL divider / VCO cap search block.
// ----------------------------------------------------------------------------
module pdvc_checker
    import pdvc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    // one word in flight: no input taken while a result waits
    a_no_take_while_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while a result word is pending");

    // readings answer in the next cycle
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_READ) |=> m_tvalid)
        else $error("reading word did not produce a result in the next cycle");

    a_out_of_band: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_START &&
         (s_tdata[TARGET_W-1:0] <= BAND_EDGE[0] ||
          s_tdata[TARGET_W-1:0] > BAND_EDGE[NUM_BANDS]))
        |=> (m_tvalid && m_tuser == STAT_OUT_BAND))
        else $error("out-of-band target not reported");

    a_ignored_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_IGNORED) |-> (m_tdata == '0))
        else $error("ignored reading carries nonzero data");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

endmodule

bind pll_divider_and_vco_cap_search pdvc_checker u_pdvc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[sim/pll_divider_and_vco_cap_search_test.sv]
// ----------------------------------------------------------------------------
// pll_divider_and_vco_cap_search_test
// Drives tune requests and comparator readings into the PLL divider / VCO cap
// search block and compares every result word with a cycle-free predictor
// of the band lookup, divider math and window search. Runs several reference
// clock settings with random idling on both stream sides.
// ----------------------------------------------------------------------------
module pll_divider_and_vco_cap_search_test;
    import pdvc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int CALM_LO       = 2500;
    localparam int CALM_HI       = 4500;
    localparam int STALL_AT      = 300;
    localparam int STALL_CYCLES  = 400;
    localparam int PHASE_ITEMS   = 91;
    localparam int LAST_CAP      = CAP_STEPS_DEF - 1;
    localparam int INT_SAT       = (1 << INT_W) - 1;

    // result word layout in m_tdata
    localparam int BANK_LO = 0;
    localparam int BAND_LO = BANK_LO + BANK_W;
    localparam int INT_LO  = BAND_LO + BAND_W;
    localparam int FRAC_LO = INT_LO + INT_W;
    localparam int CAP_LO  = FRAC_LO + FRAC_OUT_W;
    localparam int ACT_LO  = CAP_LO + CAP_OUT_W;

    typedef enum logic [1:0] {PEND_WORD, PEND_DRAIN, PEND_CFG} pend_kind_t;

    typedef struct {
        pend_kind_t           kind;
        logic                 op;
        logic [TARGET_W-1:0]  freq;
        logic [BANK_W-1:0]    bank;
        logic [COMP_W-1:0]    comp;
        logic [REF_W-1:0]     refv;
    } pend_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [BANK_W-1:0]     bank;
        logic [BAND_W-1:0]     band;
        logic [INT_W-1:0]      nint;
        logic [FRAC_OUT_W-1:0] frac;
        logic [CAP_OUT_W-1:0]  cap;
        logic [ACT_W-1:0]      actual;
    } tune_word_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REF_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    pll_divider_and_vco_cap_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    pend_t      pending_words[$];
    tune_word_t tune_results_due[$];
    pend_t      in_flight;
    int         errors = 0;
    int         cyc = 0;
    int         quiet = 0;

    // predictor state
    logic [REF_W-1:0]      ref_hz = REF_RESET;
    logic                  sweep_on = 1'b0;
    int                    cap_at = 0;
    logic [1:0]            phase = PH_ABOVE;
    int                    w_lo = 0;
    int                    w_hi = 0;
    logic [BAND_W-1:0]     h_band = '0;
    logic [INT_W-1:0]      h_int = '0;
    logic [FRAC_OUT_W-1:0] h_frac = '0;
    logic [ACT_W-1:0]      h_act = '0;
    logic [BANK_W-1:0]     h_bank = '0;

    function automatic tune_word_t held_word(logic [STATUS_W-1:0] status, int cap);
        tune_word_t r;
        r.status = status;
        r.bank   = h_bank;
        r.band   = h_band;
        r.nint   = h_int;
        r.frac   = h_frac;
        r.cap    = CAP_OUT_W'(cap);
        r.actual = h_act;
        return r;
    endfunction

    function automatic tune_word_t solve_tune(logic [TARGET_W-1:0] f, logic [BANK_W-1:0] bank);
        tune_word_t r;
        int band;
        logic [63:0] rq, x, xf, q, fr, act;
        r = '0;
        band = -1;
        sweep_on = 1'b0;
        for (int i = 0; i < NUM_BANDS; i++)
            if (band < 0 && f > BAND_EDGE[i] && f <= BAND_EDGE[i+1])
                band = i;
        if (band < 0) begin
            r.status = STAT_OUT_BAND;
            r.bank   = bank;
            return r;
        end
        rq = (ref_hz == 0) ? 64'd1 : 64'(ref_hz);
        x  = 64'd1 << (int'(BAND_CODE[band][2:0]) - 3);
        xf = x * 64'(f);
        q  = xf / rq;
        if (q > 64'(INT_SAT)) begin
            q  = 64'(INT_SAT);
            fr = (64'd1 << FRAC_BITS_DEF) - 64'd1;
        end else begin
            fr = ((xf - q * rq) << FRAC_BITS_DEF) / rq;
        end
        act = (q * rq + ((fr * rq) >> FRAC_BITS_DEF)) / x;
        if (act > 64'hFFFF_FFFF)
            act = 64'hFFFF_FFFF;
        h_band   = BAND_CODE[band];
        h_int    = q[INT_W-1:0];
        h_frac   = fr[FRAC_OUT_W-1:0];
        h_act    = act[ACT_W-1:0];
        h_bank   = bank;
        cap_at   = 0;
        phase    = PH_ABOVE;
        w_lo     = 0;
        w_hi     = 0;
        sweep_on = 1'b1;
        return held_word(STAT_SWEEPING, 0);
    endfunction

    function automatic tune_word_t advance_sweep(logic [COMP_W-1:0] comp);
        tune_word_t r;
        r = '0;
        if (!sweep_on) begin
            r.status = STAT_IGNORED;
            return r;
        end
        if (comp == COMP_INVALID) begin
            sweep_on = 1'b0;
            return held_word(STAT_BAD_READ, cap_at);
        end
        if (comp == COMP_LOW && phase == PH_IN) begin
            w_hi  = cap_at - 1;
            phase = PH_BELOW;
        end else if (comp == COMP_NORMAL && phase == PH_ABOVE) begin
            w_lo  = cap_at;
            phase = PH_IN;
        end
        if (cap_at >= LAST_CAP) begin
            sweep_on = 1'b0;
            // window still open at the last code closes there
            if (phase == PH_IN)
                w_hi = LAST_CAP;
            if (phase == PH_ABOVE)
                return held_word(STAT_NO_WINDOW, 0);
            return held_word(STAT_DONE, (w_lo + w_hi) / 2);
        end
        cap_at++;
        return held_word(STAT_SWEEPING, cap_at);
    endfunction

    function automatic bit take_gap();
        return (cyc < CALM_LO || cyc >= CALM_HI) && ($urandom_range(0, 99) < 13);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    function automatic void push_word(logic op, logic [TARGET_W-1:0] f,
                                      logic [BANK_W-1:0] bank, logic [COMP_W-1:0] comp);
        pend_t p;
        p.kind = PEND_WORD;
        p.op   = op;
        p.freq = f;
        p.bank = bank;
        p.comp = comp;
        p.refv = '0;
        pending_words.push_back(p);
    endfunction

    function automatic void push_ctrl(pend_kind_t kind, logic [REF_W-1:0] refv);
        pend_t p;
        p.kind = kind;
        p.op   = OP_START;
        p.freq = '0;
        p.bank = '0;
        p.comp = '0;
        p.refv = refv;
        pending_words.push_back(p);
    endfunction

    function automatic void push_read(logic [COMP_W-1:0] comp);
        push_word(OP_READ, $urandom, BANK_W'($urandom_range(0, 127)), comp);
    endfunction

    function automatic logic [TARGET_W-1:0] in_band_freq();
        int i;
        logic [TARGET_W-1:0] span;
        i = $urandom_range(0, NUM_BANDS - 1);
        if ($urandom_range(0, 7) == 0)
            return BAND_EDGE[i+1];
        span = BAND_EDGE[i+1] - BAND_EDGE[i];
        return BAND_EDGE[i] + 1 + ($urandom % span);
    endfunction

    // one tune scenario; n counts the words that do real work
    function automatic int queue_scenario();
        int n, pick, hi_n, win_n, cut, reads;
        logic [COMP_W-1:0] cv;
        n = 0;
        pick = $urandom_range(0, 9);
        if (pick <= 7) begin
            push_word(OP_START, in_band_freq(), BANK_W'($urandom_range(0, 127)),
                      COMP_W'($urandom_range(0, 3)));
            n++;
            hi_n  = ($urandom_range(0, 5) == 0) ? CAP_STEPS_DEF : $urandom_range(0, LAST_CAP);
            win_n = $urandom_range(1, CAP_STEPS_DEF);
            cut   = CAP_STEPS_DEF;
            if (pick == 6)
                cut = $urandom_range(0, LAST_CAP);
            else if (pick == 7)
                cut = $urandom_range(1, LAST_CAP);
            for (int c = 0; c < CAP_STEPS_DEF; c++) begin
                if (c == cut) begin
                    // bad reading ends the sweep; an abandoned sweep just stops here
                    if (pick == 6) begin
                        push_read(COMP_INVALID);
                        n++;
                    end
                    break;
                end
                if (c < hi_n)
                    cv = $urandom_range(0, 1) ? COMP_HIGH : COMP_LOW;
                else if (c < hi_n + win_n)
                    cv = ($urandom_range(0, 7) == 0) ? COMP_HIGH : COMP_NORMAL;
                else if (c == hi_n + win_n)
                    cv = COMP_LOW;
                else
                    cv = COMP_W'($urandom_range(0, 2));
                push_read(cv);
                n++;
            end
            if (pick == 0)
                push_read(COMP_W'($urandom_range(0, 3)));
        end else if (pick == 8) begin
            push_word(OP_START, $urandom, BANK_W'($urandom_range(0, 127)),
                      COMP_W'($urandom_range(0, 3)));
            n++;
            reads = $urandom_range(0, 4);
            repeat (reads) begin
                push_read(COMP_W'($urandom_range(0, 3)));
                n++;
            end
        end else begin
            if ($urandom_range(0, 1))
                push_word(OP_START, $urandom_range(0, BAND_EDGE[0]),
                          BANK_W'($urandom_range(0, 127)), COMP_W'($urandom_range(0, 3)));
            else
                push_word(OP_START, BAND_EDGE[NUM_BANDS] + 1 + $urandom_range(0, 574967294),
                          BANK_W'($urandom_range(0, 127)), COMP_W'($urandom_range(0, 3)));
            n++;
            push_read(COMP_W'($urandom_range(0, 3)));
            push_read(COMP_W'($urandom_range(0, 3)));
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // driver: input words and configuration writes
    // ------------------------------------------------------------------
    int settle = 0;

    always @(posedge aclk) begin
        pend_t head;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
            settle    <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (in_flight.op == OP_START)
                    tune_results_due.push_back(solve_tune(in_flight.freq, in_flight.bank));
                else
                    tune_results_due.push_back(advance_sweep(in_flight.comp));
            end
            if (cfg_valid && cfg_ready) begin
                ref_hz = cfg_data;
                cfg_valid <= 1'b0;
                void'(pending_words.pop_front());
            end else if (cfg_valid || (s_tvalid && !s_tready)) begin
                // hold the offered word
            end else if (pending_words.size() == 0) begin
                s_tvalid <= 1'b0;
            end else begin
                head = pending_words[0];
                if (head.kind == PEND_WORD) begin
                    if (take_gap()) begin
                        s_tvalid <= 1'b0;
                    end else begin
                        in_flight = head;
                        void'(pending_words.pop_front());
                        s_tvalid <= 1'b1;
                        s_tuser  <= head.op;
                        s_tdata  <= {S_PAD_W'(0), head.comp, head.bank, head.freq};
                    end
                end else begin
                    // drain all results, let the block settle, then write or move on
                    s_tvalid <= 1'b0;
                    if (tune_results_due.size() != 0) begin
                        settle <= 0;
                    end else if (settle < SETTLE_CYCLES) begin
                        settle <= settle + 1;
                    end else begin
                        settle <= 0;
                        if (head.kind == PEND_DRAIN) begin
                            void'(pending_words.pop_front());
                        end else begin
                            cfg_valid <= 1'b1;
                            cfg_data  <= head.refv;
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: result words
    // ------------------------------------------------------------------
    int  results_seen = 0;
    int  stall_left = 0;
    bit  stall_done = 1'b0;

    always @(posedge aclk) begin
        tune_word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (tune_results_due.size() == 0) begin
                    $error("result word with no expectation: status %0d", m_tuser);
                    errors++;
                end else begin
                    want = tune_results_due.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tuser));
                    check_field("bank_out", 32'(want.bank), 32'(m_tdata[BANK_LO +: BANK_W]));
                    check_field("band_select", 32'(want.band),
                                32'(m_tdata[BAND_LO +: BAND_W]));
                    check_field("int_divider", 32'(want.nint), 32'(m_tdata[INT_LO +: INT_W]));
                    check_field("frac_divider", 32'(want.frac),
                                32'(m_tdata[FRAC_LO +: FRAC_OUT_W]));
                    check_field("cap_code", 32'(want.cap), 32'(m_tdata[CAP_LO +: CAP_OUT_W]));
                    check_field("actual_freq_hz", want.actual, m_tdata[ACT_LO +: ACT_W]);
                end
            end
            if (!stall_done && results_seen >= STALL_AT) begin
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !take_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("pll_divider_and_vco_cap_search_test: errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        logic [REF_W-1:0] ref_list[10];
        int done_items;

        // reading while idle, out-of-band edges
        push_word(OP_READ, 32'h0, 7'h00, COMP_NORMAL);
        push_word(OP_READ, 32'hFFFF_FFFF, 7'h7F, COMP_INVALID);
        push_word(OP_START, 32'h0, 7'h00, COMP_NORMAL);
        push_word(OP_START, BAND_EDGE[0], 7'h7F, COMP_INVALID);
        push_word(OP_START, 32'hFFFF_FFFF, 7'h33, COMP_HIGH);
        push_word(OP_START, BAND_EDGE[NUM_BANDS] + 1, 7'h4C, COMP_LOW);
        // lowest in-band target, a one-code window
        push_word(OP_START, BAND_EDGE[0] + 1, 7'h01, COMP_NORMAL);
        push_word(OP_READ, 32'h0, 7'h00, COMP_HIGH);
        push_word(OP_READ, 32'h0, 7'h00, COMP_NORMAL);
        push_word(OP_READ, 32'h0, 7'h00, COMP_LOW);
        push_word(OP_READ, 32'h0, 7'h00, COMP_NORMAL);
        // restart mid-sweep at the top edge, then a bad reading at code zero
        push_word(OP_START, BAND_EDGE[NUM_BANDS], 7'h55, COMP_NORMAL);
        push_word(OP_READ, 32'hFFFF_FFFF, 7'h7F, COMP_INVALID);
        push_word(OP_READ, 32'h0, 7'h00, COMP_NORMAL);
        // upper edge of the first band is inclusive
        push_word(OP_START, BAND_EDGE[1], 7'h2A, COMP_NORMAL);
        push_word(OP_READ, 32'h0, 7'h00, COMP_LOW);
        push_word(OP_READ, 32'h0, 7'h00, COMP_NORMAL);
        push_word(OP_READ, 32'h0, 7'h00, COMP_INVALID);
        push_word(OP_START, BAND_EDGE[1] + 1, 7'h15, COMP_NORMAL);
        // out-of-band start drops the sweep
        push_word(OP_START, BAND_EDGE[12], 7'h6B, COMP_NORMAL);
        push_word(OP_READ, 32'h0, 7'h00, COMP_HIGH);
        push_word(OP_START, BAND_EDGE[NUM_BANDS] + 1, 7'h12, COMP_NORMAL);
        push_word(OP_READ, 32'h0, 7'h00, COMP_NORMAL);
        push_ctrl(PEND_DRAIN, '0);

        ref_list[0] = REF_W'(15000000);
        ref_list[1] = REF_W'(1000000000);
        ref_list[2] = '0;
        ref_list[3] = REF_W'(1);
        ref_list[4] = REF_W'($urandom);
        ref_list[5] = '1;
        ref_list[6] = REF_W'($urandom_range(15000000, 1000000000));
        ref_list[7] = REF_W'($urandom_range(15000000, 1000000000));
        ref_list[8] = REF_W'($urandom_range(15000000, 1000000000));
        ref_list[9] = REF_RESET;

        // running total, so the overshoot of one phase is taken back in the next
        done_items = 0;
        for (int ph = -1; ph < 10; ph++) begin
            if (ph >= 0)
                push_ctrl(PEND_CFG, ref_list[ph]);
            done_items += queue_scenario();
            push_ctrl(PEND_DRAIN, '0);
            while (done_items < (ph + 2) * PHASE_ITEMS)
                done_items += queue_scenario();
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || cfg_valid
                || tune_results_due.size() != 0)
            @(negedge aclk);
        repeat (200) @(negedge aclk);

        if (tune_results_due.size() != 0)
            $error("%0d result words never arrived", tune_results_due.size());
        if (errors == 0 && tune_results_due.size() == 0)
            $display("pll_divider_and_vco_cap_search_test: clean");
        else
            $display("pll_divider_and_vco_cap_search_test: errors");
        $finish;
    end

endmodule
